### design/erm_pkg.sv
// shared types and constants for the euler rotation matrix block
package erm_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // working format of the sine/cosine series: Q2.30
  localparam int WORK_BITS = 30;
  localparam int HPI_W     = 31;
  localparam logic [HPI_W-1:0] HALF_PI_W = 31'd1686629713;

  localparam int XW  = 31;  // reduced angle in radians
  localparam int X2W = 32;  // squared angle
  localparam int RW  = 33;  // signed horner accumulator
  localparam logic signed [RW-1:0] ONE_W = RW'(1) << WORK_BITS;

  localparam int HORNER_STAGES = 3;
  localparam int SIN_TERMS     = 6;
  localparam int COS_TERMS     = 7;
  localparam int LANE_LAT      = 2 + HORNER_STAGES * COS_TERMS + 1;
  localparam int MERGE_LAT     = 3;

  localparam int FIELD_W = 16;

  typedef struct packed {
    logic [FIELD_W-1:0] angle_x;
    logic [FIELD_W-1:0] angle_y;
    logic [FIELD_W-1:0] angle_z;
  } erm_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] m00;
    logic signed [FIELD_W-1:0] m01;
    logic signed [FIELD_W-1:0] m02;
    logic signed [FIELD_W-1:0] m10;
    logic signed [FIELD_W-1:0] m11;
    logic signed [FIELD_W-1:0] m12;
    logic signed [FIELD_W-1:0] m20;
    logic signed [FIELD_W-1:0] m21;
    logic signed [FIELD_W-1:0] m22;
  } erm_out_t;

endpackage

### design/erm_hstep.sv
// one horner step r' = 1 - round(round(x2*r)/DIV), three pipeline stages
module erm_hstep #(
  parameter int DIV = 2
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [erm_pkg::X2W-1:0]       x2_i,
  input  logic signed [erm_pkg::RW-1:0] r_i,
  output logic signed [erm_pkg::RW-1:0] r_o
);
  import erm_pkg::*;

  localparam int NW = 33;
  localparam int SH = 33;
  localparam int PAW = X2W + RW - 1;
  localparam logic [NW-1:0]  RECIP  = NW'((64'd1 << SH) / DIV);
  localparam logic [NW-1:0]  HALF_D = NW'(DIV / 2);
  localparam logic [NW-1:0]  D_W    = NW'(DIV);
  localparam logic [PAW-1:0] RND_A  = PAW'(1) << (WORK_BITS - 1);

  logic [RW-2:0]   rmag;
  logic [PAW-1:0]  prod_a;
  logic [NW-1:0]   pm_nxt, pm_r;
  logic            neg_a_r;
  logic [NW-1:0]   n_b;
  logic [2*NW-1:0] prod_b;
  logic [NW-1:0]   q0_nxt, q0_r, n_r;
  logic            neg_b_r;
  logic [NW:0]     rem;
  logic [NW-1:0]   q;
  logic signed [RW-1:0] r_nxt;

  // stage a: product magnitude, rounded back to the working format
  always_comb begin
    rmag   = r_i[RW-1] ? (RW-1)'(-r_i) : r_i[RW-2:0];
    prod_a = x2_i * rmag;
    pm_nxt = NW'((prod_a + RND_A) >> WORK_BITS);
  end

  // stage b: reciprocal multiply, estimate is exact or one low
  always_comb begin
    n_b    = pm_r + HALF_D;
    prod_b = n_b * RECIP;
    q0_nxt = NW'(prod_b >> SH);
  end

  // stage c: correct estimate and close the step
  always_comb begin
    rem   = (NW+1)'(n_r) - (NW+1)'(q0_r * D_W);
    q     = q0_r + NW'(rem >= (NW+1)'(DIV));
    r_nxt = neg_b_r ? $signed(ONE_W + RW'(q)) : $signed(ONE_W - RW'(q));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pm_r    <= pm_nxt;
      neg_a_r <= r_i[RW-1];
      n_r     <= n_b;
      q0_r    <= q0_nxt;
      neg_b_r <= neg_a_r;
      r_o     <= r_nxt;
    end
  end

endmodule

### design/erm_lane.sv
// sine/cosine lane: angle reduction, taylor series pipelines, quadrant fold
module erm_lane #(
  parameter int ANGLE_BITS = erm_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = erm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ANGLE_BITS-1:0]       angle_i,
  output logic signed [FRAC_BITS+1:0] sin_o,
  output logic signed [FRAC_BITS+1:0] cos_o
);
  import erm_pkg::*;

  localparam int QSH     = ANGLE_BITS - 2;
  localparam int PW      = QSH + HPI_W;
  localparam int TAPS    = HORNER_STAGES * COS_TERMS + 1;
  localparam int SIN_TAP = HORNER_STAGES * SIN_TERMS;
  localparam int SH      = WORK_BITS - FRAC_BITS;
  localparam int VW      = FRAC_BITS + 2;
  localparam int FW      = FRAC_BITS + 1;
  localparam logic [PW-1:0]      RND_X  = PW'(1) << (QSH - 1);
  localparam logic [2*XW-1:0]    RND_SQ = (2*XW)'(1) << (WORK_BITS - 1);
  localparam logic [XW+RW-2:0]   RND_M  = (XW+RW-1)'(1) << (WORK_BITS - 1);
  localparam logic [31:0]        RND_F  = (32'd1 << SH) >> 1;

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_t;

  typedef struct packed {
    quad_t          quad;
    logic [XW-1:0]  x;
    logic [X2W-1:0] x2;
  } lane_tap_t;

  logic [PW-1:0]     xprod;
  logic [XW-1:0]     x0_nxt, x0_r;
  quad_t             quad0_r;
  logic [2*XW-1:0]   sq;
  lane_tap_t         tap_nxt;
  lane_tap_t         tap_r [TAPS];

  logic signed [RW-1:0] cos_c [COS_TERMS+1];
  logic signed [RW-1:0] sin_c [SIN_TERMS+1];

  logic [RW-2:0]     srmag;
  logic [XW+RW-2:0]  sprod;
  logic [RW:0]       smag;
  logic [XW-1:0]     sw_nxt, sw_r, sw_d1_r, sw_d2_r;
  logic [XW-1:0]     cw;
  logic [FW-1:0]     s_q, c_q;
  logic signed [VW-1:0] s_v, c_v;
  logic signed [VW-1:0] sin_nxt, cos_nxt;

  // reduce to the first quadrant and scale to radians
  always_comb begin
    xprod  = angle_i[QSH-1:0] * HALF_PI_W;
    x0_nxt = XW'((xprod + RND_X) >> QSH);
  end

  always_comb begin
    sq           = x0_r * x0_r;
    tap_nxt.quad = quad0_r;
    tap_nxt.x    = x0_r;
    tap_nxt.x2   = X2W'((sq + RND_SQ) >> WORK_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r     <= x0_nxt;
      quad0_r  <= quad_t'(angle_i[ANGLE_BITS-1 -: 2]);
      tap_r[0] <= tap_nxt;
      for (int i = 1; i < TAPS; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign cos_c[0] = ONE_W;
  assign sin_c[0] = ONE_W;

  for (genvar j = 0; j < COS_TERMS; j++) begin : g_cos
    erm_hstep #(
      .DIV((2*COS_TERMS - 1 - 2*j) * (2*COS_TERMS - 2*j))
    ) u_step (
      .clk  (clk),
      .en   (en),
      .x2_i (tap_r[HORNER_STAGES*j].x2),
      .r_i  (cos_c[j]),
      .r_o  (cos_c[j+1])
    );
  end

  for (genvar j = 0; j < SIN_TERMS; j++) begin : g_sin
    erm_hstep #(
      .DIV((2*SIN_TERMS - 2*j) * (2*SIN_TERMS + 1 - 2*j))
    ) u_step (
      .clk  (clk),
      .en   (en),
      .x2_i (tap_r[HORNER_STAGES*j].x2),
      .r_i  (sin_c[j]),
      .r_o  (sin_c[j+1])
    );
  end

  // sine closes with x*r, clamped to [0, 1]
  always_comb begin
    srmag = sin_c[SIN_TERMS][RW-1] ? (RW-1)'(-sin_c[SIN_TERMS])
                                   : sin_c[SIN_TERMS][RW-2:0];
    sprod = tap_r[SIN_TAP].x * srmag;
    smag  = (RW+1)'((sprod + RND_M) >> WORK_BITS);
    if (sin_c[SIN_TERMS][RW-1]) begin
      sw_nxt = '0;
    end else if (smag > (RW+1)'(ONE_W)) begin
      sw_nxt = XW'(ONE_W);
    end else begin
      sw_nxt = XW'(smag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sw_r    <= sw_nxt;
      sw_d1_r <= sw_r;
      sw_d2_r <= sw_d1_r;
    end
  end

  // clamp cosine, round both to output precision, fold by quadrant
  always_comb begin
    if (cos_c[COS_TERMS] < 0) begin
      cw = '0;
    end else if (cos_c[COS_TERMS] > ONE_W) begin
      cw = XW'(ONE_W);
    end else begin
      cw = XW'(cos_c[COS_TERMS]);
    end
    s_q = FW'((32'(sw_d2_r) + RND_F) >> SH);
    c_q = FW'((32'(cw) + RND_F) >> SH);
    s_v = $signed({1'b0, s_q});
    c_v = $signed({1'b0, c_q});
    unique case (tap_r[TAPS-1].quad)
      QUAD_I:   begin sin_nxt = s_v;  cos_nxt = c_v;  end
      QUAD_II:  begin sin_nxt = c_v;  cos_nxt = -s_v; end
      QUAD_III: begin sin_nxt = -s_v; cos_nxt = -c_v; end
      QUAD_IV:  begin sin_nxt = -c_v; cos_nxt = s_v;  end
      default:  begin sin_nxt = s_v;  cos_nxt = c_v;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_o <= sin_nxt;
      cos_o <= cos_nxt;
    end
  end

endmodule

### design/erm_merge.sv
// merge stage: rounded products, sums and saturation of the nine entries
module erm_merge #(
  parameter int FRAC_BITS = erm_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [FRAC_BITS+1:0] sx,
  input  logic signed [FRAC_BITS+1:0] cx,
  input  logic signed [FRAC_BITS+1:0] sy,
  input  logic signed [FRAC_BITS+1:0] cy,
  input  logic signed [FRAC_BITS+1:0] sz,
  input  logic signed [FRAC_BITS+1:0] cz,
  output erm_pkg::erm_out_t           out_o
);
  import erm_pkg::*;

  localparam int VW = FRAC_BITS + 2;
  localparam int PWM = 2 * VW - 2;
  localparam logic [PWM-1:0] RND_P = (PWM'(1) << FRAC_BITS) >> 1;
  localparam logic signed [VW:0] LIM_P = (VW+1)'(1) << FRAC_BITS;
  localparam logic signed [VW:0] LIM_N = -LIM_P;

  function automatic logic signed [VW-1:0] mulf(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic [VW-2:0]  am, bm, m;
    logic [PWM-1:0] p;
    am = a[VW-1] ? (VW-1)'(-a) : a[VW-2:0];
    bm = b[VW-1] ? (VW-1)'(-b) : b[VW-2:0];
    p  = am * bm;
    m  = (VW-1)'((p + RND_P) >> FRAC_BITS);
    mulf = (a[VW-1] ^ b[VW-1]) ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat(input logic signed [VW:0] v);
    logic signed [VW:0] c;
    if (v > LIM_P) begin
      c = LIM_P;
    end else if (v < LIM_N) begin
      c = LIM_N;
    end else begin
      c = v;
    end
    sat = FIELD_W'(c);
  endfunction

  logic signed [VW-1:0] sxsy_r, cxsy_r, cycz_r, cxsz_r, sxsz_r, cysz_r;
  logic signed [VW-1:0] cxcz_r, sxcz_r, sxcy_r, cxcy_r, sz_r, cz_r, sy_r;
  logic signed [VW-1:0] a01_r, a02_r, a11_r, a12_r;
  logic signed [VW-1:0] cxsz2_r, sxsz2_r, cxcz2_r, sxcz2_r;
  logic signed [VW-1:0] cycz2_r, cysz2_r, sxcy2_r, cxcy2_r, sy2_r;
  erm_out_t             out_nxt;

  // stage 1: all two-factor products
  always_ff @(posedge clk) begin
    if (en) begin
      sxsy_r <= mulf(sx, sy);
      cxsy_r <= mulf(cx, sy);
      cycz_r <= mulf(cy, cz);
      cxsz_r <= mulf(cx, sz);
      sxsz_r <= mulf(sx, sz);
      cysz_r <= mulf(cy, sz);
      cxcz_r <= mulf(cx, cz);
      sxcz_r <= mulf(sx, cz);
      sxcy_r <= mulf(sx, cy);
      cxcy_r <= mulf(cx, cy);
      sz_r   <= sz;
      cz_r   <= cz;
      sy_r   <= sy;
    end
  end

  // stage 2: third factor of the triple products
  always_ff @(posedge clk) begin
    if (en) begin
      a01_r   <= mulf(sxsy_r, cz_r);
      a02_r   <= mulf(cxsy_r, cz_r);
      a11_r   <= mulf(sxsy_r, sz_r);
      a12_r   <= mulf(cxsy_r, sz_r);
      cxsz2_r <= cxsz_r;
      sxsz2_r <= sxsz_r;
      cxcz2_r <= cxcz_r;
      sxcz2_r <= sxcz_r;
      cycz2_r <= cycz_r;
      cysz2_r <= cysz_r;
      sxcy2_r <= sxcy_r;
      cxcy2_r <= cxcy_r;
      sy2_r   <= sy_r;
    end
  end

  // stage 3: sums and saturation
  always_comb begin
    out_nxt.m00 = sat((VW+1)'(cycz2_r));
    out_nxt.m01 = sat((VW+1)'(a01_r) - (VW+1)'(cxsz2_r));
    out_nxt.m02 = sat((VW+1)'(a02_r) + (VW+1)'(sxsz2_r));
    out_nxt.m10 = sat((VW+1)'(cysz2_r));
    out_nxt.m11 = sat((VW+1)'(a11_r) + (VW+1)'(cxcz2_r));
    out_nxt.m12 = sat((VW+1)'(a12_r) - (VW+1)'(sxcz2_r));
    out_nxt.m20 = sat(-((VW+1)'(sy2_r)));
    out_nxt.m21 = sat((VW+1)'(sxcy2_r));
    out_nxt.m22 = sat((VW+1)'(cxcy2_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_o <= out_nxt;
    end
  end

endmodule

### design/euler_rotation_matrix.sv
// euler zyx rotation matrix: three sine/cosine lanes and a product merge
// pipeline: 24 lane stages, then 3 merge stages, between input accept and out_valid
// throughput: one word per cycle unless the output stalls; each horner term is a 3-stage step in a lane
// backpressure: the whole pipe holds while a finished word waits at the output
// reset: rst_n clears only the valid pipe; datapath registers are not reset
module euler_rotation_matrix #(
  parameter int ANGLE_BITS = erm_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = erm_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  erm_pkg::erm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output erm_pkg::erm_out_t out_data
);
  import erm_pkg::*;

  localparam int LAT = LANE_LAT + MERGE_LAT;
  localparam int VW  = FRAC_BITS + 2;
  localparam int LIM = 1 << FRAC_BITS;

  // pipeline advance: output slot empty or being taken
  logic           en;
  logic [LAT-1:0] vld_r, vld_nxt;

  logic signed [VW-1:0] sx, cx, sy, cy, sz, cz;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];
  assign vld_nxt   = {vld_r[LAT-2:0], in_valid};

  // valid bit travels alongside each word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // one lane per axis
  erm_lane #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk     (clk),
    .en      (en),
    .angle_i (ANGLE_BITS'(in_data.angle_x)),
    .sin_o   (sx),
    .cos_o   (cx)
  );

  erm_lane #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk     (clk),
    .en      (en),
    .angle_i (ANGLE_BITS'(in_data.angle_y)),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  erm_lane #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk     (clk),
    .en      (en),
    .angle_i (ANGLE_BITS'(in_data.angle_z)),
    .sin_o   (sz),
    .cos_o   (cz)
  );

  // matrix products and saturation; last stage is the output register
  erm_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk   (clk),
    .en    (en),
    .sx    (sx),
    .cx    (cx),
    .sy    (sy),
    .cy    (cy),
    .sz    (sz),
    .cz    (cz),
    .out_o (out_data)
  );

  // an accepted word enters the first valid slot
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted word missing from valid pipe");

  // a blocked output freezes the whole pipe
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(vld_r) && $stable(out_data)))
    else $error("pipe moved while output stalled");

  // saturated entries m20 and m11 stay within plus or minus one
  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (FRAC_BITS > 14 ||
                   (out_data.m20 <= LIM && out_data.m20 >= -LIM &&
                    out_data.m11 <= LIM && out_data.m11 >= -LIM)))
    else $error("matrix entry outside saturation range");

endmodule

### bench/erm_checker.sv
// checker for the euler rotation matrix block: predicts each matrix and compares
module erm_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  erm_pkg::erm_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  erm_pkg::erm_out_t out_data,
  output int                fail_count,
  output int                pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import erm_pkg::*;

  localparam int AB = 16;
  localparam int FB = 14;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint HPI = 64'sd1686629713;

  erm_out_t matrix_q[$];

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint mul_rnd(longint a, longint b, int sh);
    longint m;
    m = mag(a) * mag(b);
    if (sh > 0) m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint div_rnd(longint v, longint d);
    longint m;
    m = (mag(v) + d / 2) / d;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint clamp01(longint v);
    if (v < 0) return 0;
    if (v > ONE_Q30) return ONE_Q30;
    return v;
  endfunction

  function automatic longint shr_rnd(longint v, int sh);
    longint m;
    m = (mag(v) + (64'sd1 <<< (sh - 1))) >>> sh;
    return v < 0 ? -m : m;
  endfunction

  // quadrant from the top two bits, taylor series over the first quarter turn
  function automatic void trig(logic [15:0] ang, output longint sn, output longint cs);
    int quad;
    longint t, x, x2, r, s, c;
    quad = ang[15:14];
    t = ang[13:0];
    x = (t * HPI + (64'sd1 << 13)) >>> 14;
    x2 = mul_rnd(x, x, 30);
    r = ONE_Q30;
    for (int k = 12; k >= 2; k -= 2)
      r = ONE_Q30 - div_rnd(mul_rnd(x2, r, 30), k * (k + 1));
    s = shr_rnd(clamp01(mul_rnd(x, r, 30)), 30 - FB);
    r = ONE_Q30;
    for (int k = 13; k >= 1; k -= 2)
      r = ONE_Q30 - div_rnd(mul_rnd(x2, r, 30), k * (k + 1));
    c = shr_rnd(clamp01(r), 30 - FB);
    case (quad)
      0: begin sn = s; cs = c; end
      1: begin sn = c; cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic logic [15:0] sat(longint v);
    longint lim;
    lim = 64'sd1 <<< FB;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[15:0];
  endfunction

  function automatic longint qm(longint a, longint b);
    return mul_rnd(a, b, FB);
  endfunction

  function automatic erm_out_t rotation_of(erm_in_t w);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    erm_out_t m;
    trig(w.angle_x, sx, cx);
    trig(w.angle_y, sy, cy);
    trig(w.angle_z, sz, cz);
    sxsy = qm(sx, sy);
    cxsy = qm(cx, sy);
    m.m00 = sat(qm(cy, cz));
    m.m01 = sat(qm(sxsy, cz) - qm(cx, sz));
    m.m02 = sat(qm(cxsy, cz) + qm(sx, sz));
    m.m10 = sat(qm(cy, sz));
    m.m11 = sat(qm(sxsy, sz) + qm(cx, cz));
    m.m12 = sat(qm(cxsy, sz) - qm(sx, cz));
    m.m20 = sat(-sy);
    m.m21 = sat(qm(sx, cy));
    m.m22 = sat(qm(cx, cy));
    return m;
  endfunction

  initial fail_count = 0;
  assign pending_count = matrix_q.size();

  always @(posedge clk) begin
    erm_out_t exp_m;
    if (rst_n && in_valid && in_ready) matrix_q.push_back(rotation_of(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (matrix_q.size() == 0) begin
        fail_count <= fail_count + 1;
        $display("%0t: unexpected word %h", $time, out_data);
      end else begin
        exp_m = matrix_q.pop_front();
        if (exp_m !== out_data) begin
          fail_count <= fail_count + 1;
          $display("%0t: matrix mismatch expected %h actual %h", $time, exp_m, out_data);
        end
      end
    end
  end
endmodule

### bench/tb.sv
// testbench top for the euler rotation matrix block: stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import erm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  erm_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  erm_out_t out_data;
  int fail_count, pending_count;
  bit sending_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  euler_rotation_matrix dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  erm_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // offer one word and hold it until the block takes it
  task automatic send_word(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
    in_valid <= 1'b1;
    in_data <= '{angle_x: ax, angle_y: ay, angle_z: az};
    do @(posedge clk); while (!in_ready);
  endtask

  // a gap only drops valid when one is actually wanted
  task automatic idle_sender(bit quiet);
    int g;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // quarter-turn boundaries, their neighbors and quadrant midpoints
  function automatic logic [15:0] corner_angle();
    logic [15:0] base;
    base = 16'($urandom_range(3)) << 14;
    case ($urandom_range(3))
      0: return base;
      1: return base - 16'd1;
      2: return base + 16'd1;
      default: return base + 16'h2000;
    endcase
  endfunction

  logic [15:0] corners [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                               16'hFFFF, 16'h3FFF, 16'h0001, 16'h2000};

  // stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: axis corners, all-ones, alternating bit patterns, all-zeros and a mixed word
    for (int i = 0; i < 8; i++) begin
      send_word(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
      idle_sender(i < 4);
    end
    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(16'h5555, 16'hAAAA, 16'h5555);
    send_word(16'hAAAA, 16'h5555, 16'hAAAA);
    send_word(16'h0000, 16'h0000, 16'h0000);
    send_word(16'h1000, 16'h3000, 16'hE000);
    // random: full-range angles mixed with quadrant-edge angles
    for (int i = 0; i < 600; i++) begin
      if ($urandom_range(3) == 0)
        send_word(corner_angle(), 16'($urandom), corner_angle());
      else
        send_word(16'($urandom), 16'($urandom), 16'($urandom));
      idle_sender(i >= 200 && i < 300);
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // receiver: random stalls, one long hold-off to fill the pipe
  initial begin
    int g;
    @(posedge rst_n);
    repeat (20) @(posedge clk);
    out_ready <= 1'b0;
    repeat (120) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      g = $urandom_range(3) == 0 ? gap_len() : 0;
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // verdict once everything has drained
  initial begin
    wait (sending_done);
    // let the checker record the last accepted word first
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("[euler_rotation_matrix] OK");
    else $display("[euler_rotation_matrix] ERROR");
    $finish;
  end

  // hard stop
  initial begin
    #2ms;
    $display("[euler_rotation_matrix] ERROR");
    $finish;
  end
endmodule
